[rtl/mas_pkg.sv]
package mas_pkg;
   localparam int MAX_DIM = 8;
   localparam int ELEM_WIDTH = 16;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int VAL_W = 35;
   localparam int PROD_W = 2 * ELEM_WIDTH;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   localparam logic [2:0] REG_ROWS_A = 3'd0;
   localparam logic [2:0] REG_COLS_A = 3'd1;
   localparam logic [2:0] REG_ROWS_B = 3'd2;
   localparam logic [2:0] REG_COLS_B = 3'd3;
   localparam logic [2:0] REG_OPERATION = 3'd4;

   typedef enum logic [1:0] {
      JOB_ADD,
      JOB_SUB,
      JOB_MUL,
      JOB_ERR
   } job_kind_type;

   // One queued job: what the back end has to compute.
   typedef struct packed {
      job_kind_type kind;
      logic [IDX_W-1:0] last_row;
      logic [IDX_W-1:0] last_col;
      logic [IDX_W-1:0] last_k;
      logic [3:0] cols_a;
      logic [3:0] cols_b;
   } job_type;

   typedef struct packed {
      logic we;
      logic sel;
      logic [ADDR_W-1:0] addr;
      logic [ELEM_WIDTH-1:0] data;
   } store_wr_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_READ,
      BE_ACC,
      BE_EMIT
   } be_state_type;
endpackage

[rtl/matrix_add_sub_multiply.sv]
// Matrix add, subtract and multiply engine. Elements of A and B are loaded
// one per cycle (start with busy low), row-major. The transaction that
// completes B queues a job; the back end then reads both stores through one
// registered read port each and emits one result per output element, with
// last_result on the final one (or a single status result on a dimension
// mismatch or an invalid size or operation). Add and subtract pass each
// result through READ, ACC and EMIT; multiply repeats READ and ACC for
// each k in the single multiply-accumulate unit before EMIT. busy is high
// while a job is queued or running; loading for the next run waits for it.
// Results appear on rsp_ ports for one cycle each and cannot be held off.
module matrix_add_sub_multiply (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_matrix_select,
   input  logic signed [15:0] req_element,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [3:0] csr_data,
   output logic rsp_strobe,
   output logic signed [34:0] rsp_result_value,
   output logic [2:0] rsp_result_row,
   output logic [2:0] rsp_result_col,
   output logic rsp_status,
   output logic rsp_last_result
);
   logic [3:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [1:0] operation_ff;
   logic accept, job_push, job_pop, back_active;
   mas_pkg::store_wr_type wr;
   mas_pkg::job_type job_new;
   mas_pkg::job_type q_ff;
   logic q_v_ff;

   assign csr_ready = 1'b1;
   assign busy = q_v_ff || back_active;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= 4'd8;
         cols_a_ff <= 4'd8;
         rows_b_ff <= 4'd8;
         cols_b_ff <= 4'd8;
         operation_ff <= mas_pkg::OP_ADD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mas_pkg::REG_ROWS_A: rows_a_ff <= csr_data;
            mas_pkg::REG_COLS_A: cols_a_ff <= csr_data;
            mas_pkg::REG_ROWS_B: rows_b_ff <= csr_data;
            mas_pkg::REG_COLS_B: cols_b_ff <= csr_data;
            mas_pkg::REG_OPERATION: operation_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // One-entry job queue between front and back.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_v_ff <= 1'b0;
      end else if (job_push) begin
         q_v_ff <= 1'b1;
      end else if (job_pop) begin
         q_v_ff <= 1'b0;
      end
      if (job_push) q_ff <= job_new;
   end

   mas_front u_front (
      .clock(clock), .reset(reset), .req_accept(accept),
      .req_matrix_select(req_matrix_select), .req_element(req_element),
      .rows_a(rows_a_ff), .cols_a(cols_a_ff), .rows_b(rows_b_ff),
      .cols_b(cols_b_ff), .operation(operation_ff), .wr(wr),
      .job_push(job_push), .job(job_new)
   );

   mas_back u_back (
      .clock(clock), .reset(reset), .wr(wr), .job_valid(q_v_ff), .job(q_ff),
      .job_pop(job_pop), .active(back_active), .rsp_strobe(rsp_strobe),
      .rsp_result_value(rsp_result_value), .rsp_result_row(rsp_result_row),
      .rsp_result_col(rsp_result_col), .rsp_status(rsp_status),
      .rsp_last_result(rsp_last_result)
   );
endmodule

[rtl/mas_front.sv]
module mas_front (
   input  logic clock,
   input  logic reset,
   input  logic req_accept,
   input  logic req_matrix_select,
   input  logic signed [mas_pkg::ELEM_WIDTH-1:0] req_element,
   input  logic [3:0] rows_a,
   input  logic [3:0] cols_a,
   input  logic [3:0] rows_b,
   input  logic [3:0] cols_b,
   input  logic [1:0] operation,
   output mas_pkg::store_wr_type wr,
   output logic job_push,
   output mas_pkg::job_type job
);
   localparam int CNT_W = mas_pkg::ADDR_W + 1;
   logic [CNT_W-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic va, vb, b_done;
   logic [7:0] cap_a, size_b;

   always_comb begin
      va = (rows_a != 4'd0) && (rows_a <= 4'(mas_pkg::MAX_DIM)) &&
           (cols_a != 4'd0) && (cols_a <= 4'(mas_pkg::MAX_DIM));
      vb = (rows_b != 4'd0) && (rows_b <= 4'(mas_pkg::MAX_DIM)) &&
           (cols_b != 4'd0) && (cols_b <= 4'(mas_pkg::MAX_DIM));
      cap_a = va ? 8'(rows_a) * 8'(cols_a) : 8'(mas_pkg::DEPTH);
      size_b = vb ? 8'(rows_b) * 8'(cols_b) : 8'd1;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      wr = '0;
      wr.sel = req_matrix_select;
      wr.data = req_element;
      b_done = 1'b0;
      job_push = 1'b0;
      job = '0;
      job.last_row = mas_pkg::IDX_W'(rows_a - 4'd1);
      job.last_col = mas_pkg::IDX_W'((operation == mas_pkg::OP_MUL) ? cols_b - 4'd1
                                                                    : cols_a - 4'd1);
      job.last_k = mas_pkg::IDX_W'(cols_a - 4'd1);
      job.cols_a = cols_a;
      job.cols_b = cols_b;
      if (va && vb && (operation == mas_pkg::OP_ADD || operation == mas_pkg::OP_SUB)
          && rows_a == rows_b && cols_a == cols_b) begin
         job.kind = (operation == mas_pkg::OP_ADD) ? mas_pkg::JOB_ADD : mas_pkg::JOB_SUB;
      end else if (va && vb && operation == mas_pkg::OP_MUL && cols_a == rows_b) begin
         job.kind = mas_pkg::JOB_MUL;
      end else begin
         job.kind = mas_pkg::JOB_ERR;
      end
      if (req_accept) begin
         if (!req_matrix_select) begin
            if (8'(count_a_ff) < cap_a && count_a_ff < CNT_W'(mas_pkg::DEPTH)) begin
               wr.we = 1'b1;
               wr.addr = count_a_ff[mas_pkg::ADDR_W-1:0];
               count_a_in = count_a_ff + 1'b1;
            end
         end else begin
            wr.we = count_b_ff < CNT_W'(mas_pkg::DEPTH);
            wr.addr = count_b_ff[mas_pkg::ADDR_W-1:0];
            b_done = !(8'(count_b_ff) + 8'd1 < size_b);
            if (b_done) begin
               job_push = 1'b1;
               count_a_in = '0;
               count_b_in = '0;
            end else begin
               count_b_in = count_b_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end
endmodule

[rtl/mas_back.sv]
module mas_back (
   input  logic clock,
   input  logic reset,
   input  mas_pkg::store_wr_type wr,
   input  logic job_valid,
   input  mas_pkg::job_type job,
   output logic job_pop,
   output logic active,
   output logic rsp_strobe,
   output logic signed [mas_pkg::VAL_W-1:0] rsp_result_value,
   output logic [mas_pkg::IDX_W-1:0] rsp_result_row,
   output logic [mas_pkg::IDX_W-1:0] rsp_result_col,
   output logic rsp_status,
   output logic rsp_last_result
);
   localparam int AW = mas_pkg::ADDR_W;
   localparam int EW = mas_pkg::ELEM_WIDTH;
   localparam int VW = mas_pkg::VAL_W;

   logic [EW-1:0] mem_a [mas_pkg::DEPTH];
   logic [EW-1:0] mem_b [mas_pkg::DEPTH];
   logic signed [EW-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] addr_a, addr_b;

   mas_pkg::be_state_type state_ff, state_in;
   mas_pkg::job_type job_ff, job_in;
   logic [mas_pkg::IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [VW-1:0] acc_ff, acc_in;
   logic signed [mas_pkg::PROD_W-1:0] prod;
   logic signed [EW:0] sum;
   logic out_v_ff, out_v_in;
   logic signed [VW-1:0] out_val_ff, out_val_in;
   logic [mas_pkg::IDX_W-1:0] out_r_ff, out_r_in, out_c_ff, out_c_in;
   logic out_st_ff, out_st_in, out_l_ff, out_l_in;
   logic last_k, last_elem;

   always_ff @(posedge clock) begin
      if (wr.we && !wr.sel) mem_a[wr.addr] <= wr.data;
      if (wr.we && wr.sel) mem_b[wr.addr] <= wr.data;
      rd_a_ff <= mem_a[addr_a];
      rd_b_ff <= mem_b[addr_b];
   end

   always_comb begin
      if (job_ff.kind == mas_pkg::JOB_MUL) begin
         addr_a = AW'(8'(i_ff) * 8'(job_ff.cols_a) + 8'(k_ff));
         addr_b = AW'(8'(k_ff) * 8'(job_ff.cols_b) + 8'(j_ff));
      end else begin
         addr_a = AW'(8'(i_ff) * 8'(job_ff.cols_a) + 8'(j_ff));
         addr_b = addr_a;
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      job_pop = 1'b0;
      out_v_in = 1'b0;
      out_val_in = out_val_ff;
      out_r_in = out_r_ff;
      out_c_in = out_c_ff;
      out_st_in = out_st_ff;
      out_l_in = out_l_ff;
      prod = rd_a_ff * rd_b_ff;
      sum = (job_ff.kind == mas_pkg::JOB_ADD) ? rd_a_ff + rd_b_ff : rd_a_ff - rd_b_ff;
      last_k = (job_ff.kind != mas_pkg::JOB_MUL) || (k_ff == job_ff.last_k);
      last_elem = (i_ff == job_ff.last_row) && (j_ff == job_ff.last_col);
      case (state_ff)
         mas_pkg::BE_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in = job;
               i_in = '0;
               j_in = '0;
               k_in = '0;
               acc_in = '0;
               state_in = mas_pkg::BE_READ;
            end
         end
         mas_pkg::BE_READ: begin
            if (job_ff.kind == mas_pkg::JOB_ERR) begin
               out_v_in = 1'b1;
               out_val_in = '0;
               out_r_in = '0;
               out_c_in = '0;
               out_st_in = 1'b1;
               out_l_in = 1'b1;
               state_in = mas_pkg::BE_IDLE;
            end else begin
               state_in = mas_pkg::BE_ACC;
            end
         end
         mas_pkg::BE_ACC: begin
            // Read data for the current address is now registered.
            if (job_ff.kind == mas_pkg::JOB_MUL) begin
               acc_in = acc_ff + VW'(prod);
            end else begin
               acc_in = VW'(sum) <<< 8;
            end
            if (last_k) begin
               state_in = mas_pkg::BE_EMIT;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = mas_pkg::BE_READ;
            end
         end
         mas_pkg::BE_EMIT: begin
            out_v_in = 1'b1;
            out_val_in = acc_ff;
            out_r_in = i_ff;
            out_c_in = j_ff;
            out_st_in = 1'b0;
            out_l_in = last_elem;
            acc_in = '0;
            k_in = '0;
            if (last_elem) begin
               state_in = mas_pkg::BE_IDLE;
            end else begin
               if (j_ff == job_ff.last_col) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
               state_in = mas_pkg::BE_READ;
            end
         end
         default: state_in = mas_pkg::BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mas_pkg::BE_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      job_ff <= job_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      out_val_ff <= out_val_in;
      out_r_ff <= out_r_in;
      out_c_ff <= out_c_in;
      out_st_ff <= out_st_in;
      out_l_ff <= out_l_in;
   end

   assign active = (state_ff != mas_pkg::BE_IDLE);
   assign rsp_strobe = out_v_ff;
   assign rsp_result_value = out_val_ff;
   assign rsp_result_row = out_r_ff;
   assign rsp_result_col = out_c_ff;
   assign rsp_status = out_st_ff;
   assign rsp_last_result = out_l_ff;
endmodule
